/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

   // Request codes carried in req_tuser
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // Status codes carried in rsp_tuser
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_EMPTY     = 2'd1;
   localparam logic [1:0] STS_FULL_DROP = 2'd2;

   localparam int PRIO_W  = 3;
   localparam int PAY_W   = 32;
   localparam int COUNT_W = 5;

   typedef logic [PRIO_W-1:0] prio_type;

   // Broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic     insert;    // enqueue accepted and queue not full
      logic     remove;    // dequeue accepted and queue not empty
      prio_type prio;      // priority of the entry being inserted
   } cell_ctrl_type;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell #(
   parameter int PW = 32
) (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic [PW-1:0]          new_pay,
   input  logic                   occ,
   input  logic                   left_take,
   input  spq_pkg::prio_type      left_prio,
   input  logic [PW-1:0]          left_pay,
   input  spq_pkg::prio_type      right_prio,
   input  logic [PW-1:0]          right_pay,
   output logic                   take,
   output spq_pkg::prio_type      prio,
   output logic [PW-1:0]          pay
);
   import spq_pkg::*;

   prio_type      prio_ff, prio_in;
   logic [PW-1:0] pay_ff, pay_in;

   // Cell sits at or behind the insertion point: its entry is strictly
   // less urgent than the new one, or it holds nothing yet
   assign take = occ ? (prio_ff > ctrl.prio) : 1'b1;

   // Shift right on insert, shift left on remove, else hold
   always_comb begin
      prio_in = prio_ff;
      pay_in  = pay_ff;
      if (ctrl.insert) begin
         if (left_take) begin
            prio_in = left_prio;
            pay_in  = left_pay;
         end else if (take) begin
            prio_in = ctrl.prio;
            pay_in  = new_pay;
         end
      end else if (ctrl.remove) begin
         prio_in = right_prio;
         pay_in  = right_pay;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      pay_ff  <= pay_in;
   end

   assign prio = prio_ff;
   assign pay  = pay_ff;

endmodule

/* rtl/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                          | tuser
// req     | in        | priority_req[2:0], payload[34:3], 0 pad     | req_type[1:0]
// rsp     | out       | out_priority[2:0], out_payload[34:3],       | status[1:0],
//         |           | entry_count[39:35], is_empty[40], 0 pad     | out_valid[2]
//
// One request per cycle: the chain of cells compares every slot at once and
// shifts all of them together, so a transfer is accepted whenever the result
// register is empty or being drained in the same cycle. The result is registered.
// Synchronous active-high reset empties the queue and the result register;
// slot contents are not reset. A stalled rsp side holds the result and req.

module stable_priority_queue_unit #(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // priority_req, payload
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_priority, out_payload, entry_count, is_empty
   output logic [2:0]  rsp_tuser    // status, out_valid
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff, status_in;
   logic              oval_ff, oval_in;
   prio_type          oprio_ff, oprio_in;
   logic [PAY_W-1:0]  opay_ff, opay_in;
   logic [COUNT_W-1:0] ocount_ff;
   logic              oempty_ff;

   logic              xfer;
   logic [1:0]        req_type;
   prio_type          req_prio;
   logic [PAY_W-1:0]  req_pay;
   logic [PAYLOAD_WIDTH-1:0] new_pay;
   cell_ctrl_type     ctrl;

   prio_type                 cell_prio [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] cell_pay  [DEPTH];
   logic [DEPTH-1:0]         cell_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign xfer       = req_tvalid && req_tready;

   assign req_type = req_tuser;
   assign req_prio = req_tdata[2:0];
   assign req_pay  = req_tdata[34:3];

   generate
      if (PAYLOAD_WIDTH >= PAY_W) begin : g_pay_ext
         assign new_pay = PAYLOAD_WIDTH'(req_pay);
      end else begin : g_pay_trunc
         assign new_pay = req_pay[PAYLOAD_WIDTH-1:0];
      end
   endgenerate

   // Broadcast control for the cell chain
   always_comb begin
      ctrl.insert = xfer && (req_type == REQ_ENQUEUE) && (count_ff != FULL_COUNT);
      ctrl.remove = xfer && (req_type == REQ_DEQUEUE) && (count_ff != '0);
      ctrl.prio   = req_prio;
   end

   // Row of slots, head in cell 0
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                     occ;
         logic                     l_take;
         prio_type                 l_prio, r_prio;
         logic [PAYLOAD_WIDTH-1:0] l_pay, r_pay;

         assign occ = (CW'(i) < count_ff);

         if (i == 0) begin : g_first
            assign l_take = 1'b0;
            assign l_prio = cell_prio[i];
            assign l_pay  = cell_pay[i];
         end else begin : g_mid
            assign l_take = cell_take[i-1];
            assign l_prio = cell_prio[i-1];
            assign l_pay  = cell_pay[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign r_prio = cell_prio[i];
            assign r_pay  = cell_pay[i];
         end else begin : g_inner
            assign r_prio = cell_prio[i+1];
            assign r_pay  = cell_pay[i+1];
         end

         spq_cell #(.PW(PAYLOAD_WIDTH)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .new_pay    (new_pay),
            .occ        (occ),
            .left_take  (l_take),
            .left_prio  (l_prio),
            .left_pay   (l_pay),
            .right_prio (r_prio),
            .right_pay  (r_pay),
            .take       (cell_take[i]),
            .prio       (cell_prio[i]),
            .pay        (cell_pay[i])
         );
      end
   endgenerate

   // Next count and result fields
   always_comb begin
      count_in  = count_ff;
      status_in = STS_OK;
      oval_in   = 1'b0;
      oprio_in  = '0;
      opay_in   = '0;
      case (req_type)
         REQ_ENQUEUE: begin
            if (count_ff == FULL_COUNT) begin
               status_in = STS_FULL_DROP;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         REQ_DEQUEUE: begin
            if (count_ff == '0) begin
               status_in = STS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               oval_in  = 1'b1;
               oprio_in = cell_prio[0];
               if (PAYLOAD_WIDTH >= PAY_W) begin
                  opay_in = cell_pay[0][PAY_W-1:0];
               end else begin
                  opay_in = PAY_W'(cell_pay[0]);
               end
            end
         end
         REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Queue count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (xfer) begin
            count_ff <= count_in;
         end
         if (xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         status_ff <= status_in;
         oval_ff   <= oval_in;
         oprio_ff  <= oprio_in;
         opay_ff   <= opay_in;
         if (CW >= COUNT_W) begin
            ocount_ff <= count_in[COUNT_W-1:0];
         end else begin
            ocount_ff <= COUNT_W'(count_in);
         end
         oempty_ff <= (count_in == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, oempty_ff, ocount_ff, opay_ff, oprio_ff};
   assign rsp_tuser  = {oval_ff, status_ff};

endmodule

/* verif/stable_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
   import spq_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER = 300;
   localparam int DRAIN_CYCLES = 8;

   // Request code with no meaning; the queue must leave its state alone
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // One result transfer, unpacked
   typedef struct packed {
      logic [1:0]         status;
      logic               served;
      prio_type           prio;
      logic [PAY_W-1:0]   pay;
      logic [COUNT_W-1:0] count;
      logic               empty;
   } outcome_type;

   // One row of the directed table
   typedef struct {
      logic [1:0]       kind;
      prio_type         prio;
      logic [PAY_W-1:0] pay;
      bit               typed;
      outcome_type      want;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // priority_req, payload
   logic [1:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // out_priority, out_payload, entry_count, is_empty
   logic [2:0]  rsp_tuser;        // status, out_valid

   // Shadow copy of the queue contents, slot 0 is the head
   prio_type         shadow_prio [DEPTH];
   logic [PAY_W-1:0] shadow_pay [DEPTH];
   int               shadow_count = 0;

   outcome_type  pending_outcomes[$];
   step_row_type plan[$];
   int        mismatches = 0;
   int        results_seen = 0;
   int        quiet_cycles = 0;
   int        calm_items = 0;
   bit        rsp_held = 1'b0;
   bit        pressure_done = 1'b0;

   stable_priority_queue_unit #(
      .DEPTH(DEPTH),
      .PAYLOAD_WIDTH(PAY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow queue and return what the block should report
   function automatic outcome_type serve_request(logic [1:0] kind, prio_type prio,
                                                 logic [PAY_W-1:0] pay);
      outcome_type r;
      int pos;
      int i;
      r = '0;
      case (kind)
         REQ_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               r.status = STS_FULL_DROP;
            end else begin
               // new entry goes behind every entry with an equal or smaller priority code
               pos = 0;
               while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_prio[i] = shadow_prio[i-1];
                  shadow_pay[i] = shadow_pay[i-1];
               end
               shadow_prio[pos] = prio;
               shadow_pay[pos] = pay;
               shadow_count++;
            end
         end
         REQ_DEQUEUE: begin
            if (shadow_count == 0) begin
               r.status = STS_EMPTY;
            end else begin
               r.served = 1'b1;
               r.prio = shadow_prio[0];
               r.pay = shadow_pay[0];
               for (i = 1; i < shadow_count; i++) begin
                  shadow_prio[i-1] = shadow_prio[i];
                  shadow_pay[i-1] = shadow_pay[i];
               end
               shadow_count--;
            end
         end
         REQ_CLEAR: shadow_count = 0;
         default: ;
      endcase
      r.count = COUNT_W'(shadow_count);
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long gap
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_row(logic [1:0] kind, prio_type prio, logic [PAY_W-1:0] pay,
                                   bit typed, outcome_type want);
      step_row_type row;
      row.kind = kind;
      row.prio = prio;
      row.pay = pay;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("[%0t] result %0d: %s expected %0h got %0h", $time, results_seen, what,
               want, got);
      mismatches++;
   endtask

   // Offer one request, wait for its transfer, then log what it should produce
   task automatic send_request(logic [1:0] kind, prio_type prio, logic [PAY_W-1:0] pay,
                               bit typed, outcome_type want);
      outcome_type predicted;
      int gap;
      if (rsp_held || calm_items > 0) begin
         gap = 0;
         if (calm_items > 0) calm_items--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 39) == 0) calm_items = 40;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'b0, pay, prio};
      do @(posedge clock); while (!req_tready);
      predicted = serve_request(kind, prio, pay);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off
   initial begin : drain_side
      int stall;
      int run;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         run = 1;
         if ($urandom_range(0, 39) == 0) begin
            stall = 0;
            run = 50;
         end
         if (!pressure_done && results_seen >= HOLD_AFTER) begin
            pressure_done = 1'b1;
            rsp_held = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_held = 1'b0;
         end
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   // Check every result transfer against the oldest pending outcome
   always @(posedge clock) begin : check_results
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[1:0];
         got.served = rsp_tuser[2];
         got.prio = rsp_tdata[2:0];
         got.pay = rsp_tdata[34:3];
         got.count = rsp_tdata[39:35];
         got.empty = rsp_tdata[40];
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with nothing pending", '0, 64'(got));
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.served !== want.served)
               report_mismatch("out_valid", 64'(want.served), 64'(got.served));
            if (got.prio !== want.prio)
               report_mismatch("out_priority", 64'(want.prio), 64'(got.prio));
            if (got.pay !== want.pay)
               report_mismatch("out_payload", 64'(want.pay), 64'(got.pay));
            if (got.count !== want.count)
               report_mismatch("entry_count", 64'(want.count), 64'(got.count));
            if (got.empty !== want.empty)
               report_mismatch("is_empty", 64'(want.empty), 64'(got.empty));
         end
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stalled for %0d cycles with %0d results pending", quiet_cycles,
                  pending_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int sent;
      int mode;
      int len;
      int k;
      int roll;
      bit narrow;
      logic [1:0] kind;
      prio_type prio;

      // Directed table: empty queue cases, extremes, tie order, fill to full, clear
      add_row(REQ_DEQUEUE, 3'd0, 32'h0, 1'b1, '{STS_EMPTY, 1'b0, 3'd0, 32'h0, 5'd0, 1'b1});
      add_row(REQ_CLEAR, 3'd0, 32'h0, 1'b1, '{STS_OK, 1'b0, 3'd0, 32'h0, 5'd0, 1'b1});
      add_row(REQ_ENQUEUE, 3'd0, 32'h0, 1'b1, '{STS_OK, 1'b0, 3'd0, 32'h0, 5'd1, 1'b0});
      add_row(REQ_ENQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1,
              '{STS_OK, 1'b0, 3'd0, 32'h0, 5'd2, 1'b0});
      add_row(REQ_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1,
              '{STS_OK, 1'b0, 3'd0, 32'h0, 5'd2, 1'b0});
      add_row(REQ_ENQUEUE, 3'd4, 32'hA5A5_5A5A, 1'b0, '0);
      add_row(REQ_ENQUEUE, 3'd4, 32'h5A5A_A5A5, 1'b0, '0);
      add_row(REQ_DEQUEUE, 3'd0, 32'h0, 1'b1, '{STS_OK, 1'b1, 3'd0, 32'h0, 5'd3, 1'b0});
      add_row(REQ_DEQUEUE, 3'd0, 32'h0, 1'b0, '0);
      // two entries left; fill the rest, every priority code shows up
      for (k = 0; k < DEPTH - 2; k++)
         add_row(REQ_ENQUEUE, prio_type'(k % 8), $urandom(), 1'b0, '0);
      add_row(REQ_ENQUEUE, 3'd3, 32'h1234_5678, 1'b1,
              '{STS_FULL_DROP, 1'b0, 3'd0, 32'h0, 5'd16, 1'b0});
      add_row(REQ_CLEAR, 3'd0, 32'h0, 1'b1, '{STS_OK, 1'b0, 3'd0, 32'h0, 5'd0, 1'b1});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_request(plan[i].kind, plan[i].prio, plan[i].pay, plan[i].typed,
                                     plan[i].want);

      // Random bursts: fill-heavy, drain-heavy or mixed, with rare clears and unused codes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         len = $urandom_range(4, 40);
         narrow = ($urandom_range(0, 2) == 0);
         for (k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               0: kind = (roll < 85) ? REQ_ENQUEUE : REQ_DEQUEUE;
               1: kind = (roll < 85) ? REQ_DEQUEUE : REQ_ENQUEUE;
               default: kind = (roll < 50) ? REQ_ENQUEUE : REQ_DEQUEUE;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2) kind = REQ_CLEAR;
            else if (roll < 4) kind = REQ_UNUSED;
            // narrow bursts pile up ties to exercise arrival order
            if (narrow) prio = prio_type'($urandom_range(0, 1));
            else if ($urandom_range(0, 9) < 8) prio = prio_type'($urandom_range(0, 4));
            else prio = prio_type'($urandom_range(5, 7));
            send_request(kind, prio, $urandom(), 1'b0, '0);
            if (kind != REQ_UNUSED) sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
